// ===== sv/iectmr_pkg.sv =====
// Package with the types, constants and register codes of the PLC timer.
`timescale 1ns / 1ps
package iectmr_pkg;

    // Widths of the elapsed counter and of the millisecond accumulator.
    localparam int COUNT_BITS = 16;
    localparam int ACC_BITS   = 32;
    localparam int CMP_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESET  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_MS = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_MS = 2'd3;

    // Reset values of the timing registers.
    localparam logic [15:0] BASE_MS_RESET = 16'd1000;
    localparam logic [15:0] TICK_MS_RESET = 16'd10;

    // Timer modes; the fourth code freezes the timer.
    typedef enum logic [1:0] {
        MODE_ON_DELAY  = 2'd0,
        MODE_OFF_DELAY = 2'd1,
        MODE_PULSE     = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] preset;
        logic [15:0] base_ms;
        logic [15:0] tick_ms;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  done;
        logic                  started;
        logic                  prev_in;
        logic [ACC_BITS-1:0]   acc;
    } t_tmr_state;

    typedef struct packed {
        logic run_input;
    } t_in_beat;

    typedef struct packed {
        logic        done_res;
        logic [15:0] elapsed;
    } t_out_beat;

endpackage

// ===== sv/iectmr_if.sv =====
// Valid/ready stream interfaces for scan ticks and timer results.
`timescale 1ns / 1ps
interface iectmr_in_if;
    logic                valid;
    logic                ready;
    iectmr_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iectmr_out_if;
    logic                 valid;
    logic                 ready;
    iectmr_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/iectmr_core.sv =====
// Timer state registers and the single-pass next-state logic for one scan tick.
`timescale 1ns / 1ps
module iectmr_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_run,
    input  iectmr_pkg::t_cfg        i_cfg,
    output iectmr_pkg::t_tmr_state  o_state,
    output iectmr_pkg::t_out_beat   o_result
);

    localparam logic [iectmr_pkg::COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [iectmr_pkg::ACC_BITS-1:0]   ACC_MAX = '1;

    iectmr_pkg::t_tmr_state r_state;
    iectmr_pkg::t_tmr_state n_state;

    logic                              below_preset;
    logic                              count_now;
    logic                              mode_timed;
    logic [iectmr_pkg::ACC_BITS:0]     acc_sum;
    logic [iectmr_pkg::ACC_BITS-1:0]   acc_sat;
    logic [iectmr_pkg::ACC_BITS-1:0]   base_ext;

    assign below_preset = iectmr_pkg::CMP_BITS'(r_state.count)
                        < iectmr_pkg::CMP_BITS'(i_cfg.preset);
    assign base_ext = iectmr_pkg::ACC_BITS'(i_cfg.base_ms);

    // Saturating millisecond accumulation.
    assign acc_sum = {1'b0, r_state.acc} + (iectmr_pkg::ACC_BITS + 1)'(i_cfg.tick_ms);
    assign acc_sat = acc_sum[iectmr_pkg::ACC_BITS] ? ACC_MAX
                                                   : acc_sum[iectmr_pkg::ACC_BITS-1:0];

    // Mode logic, then timeout or counting, then the time base.
    always_comb begin
        n_state    = r_state;
        count_now  = 1'b0;
        mode_timed = 1'b0;
        unique case (i_cfg.mode)
            iectmr_pkg::MODE_ON_DELAY: begin
                if (!i_run) begin
                    n_state.done  = 1'b0;
                    n_state.count = '0;
                end else if (below_preset) begin
                    count_now = 1'b1;
                end else begin
                    n_state.done = 1'b1;
                end
            end
            iectmr_pkg::MODE_OFF_DELAY: begin
                mode_timed = 1'b1;
                if (i_run) begin
                    n_state.done    = 1'b1;
                    n_state.count   = '0;
                    n_state.started = 1'b0;
                end else if (r_state.prev_in) begin
                    n_state.started = 1'b1;
                end
            end
            iectmr_pkg::MODE_PULSE: begin
                mode_timed = 1'b1;
                if (i_run && !r_state.prev_in && !r_state.started) begin
                    n_state.done    = 1'b1;
                    n_state.count   = '0;
                    n_state.started = 1'b1;
                end
            end
            default: begin
                // Unused mode: everything but the previous input holds.
            end
        endcase

        if (mode_timed && n_state.started) begin
            if (iectmr_pkg::CMP_BITS'(n_state.count)
                    < iectmr_pkg::CMP_BITS'(i_cfg.preset)) begin
                count_now = 1'b1;
            end else begin
                n_state.done    = 1'b0;
                n_state.count   = '0;
                n_state.started = 1'b0;
            end
        end

        if (count_now) begin
            n_state.acc = acc_sat;
            if (acc_sat >= base_ext) begin
                if (n_state.count != CNT_MAX) begin
                    n_state.count = n_state.count + 1'b1;
                end
                n_state.acc = acc_sat - base_ext;
            end
        end

        n_state.prev_in = i_run;
    end

    // State advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_state           = r_state;
    assign o_result.done_res = n_state.done;
    assign o_result.elapsed  = 16'(n_state.count);

endmodule

// ===== sv/iec_timer_on_off_pulse.sv =====
// Top level of the PLC timer: configuration, input register, core and result register.
//
// Usage: each beat on i_in carries one scan tick with the rung input bit
// run_input. For every tick the block returns exactly one beat on o_res
// with the timer output done_res and the elapsed count in base units.
// Registers (mode, preset, base_ms, tick_ms) are written through
// i_cfg_we / i_cfg_idx / i_cfg_data while no tick is in flight.
// Flow: an accepted tick waits in the input register and is processed when the
// result register is free or being emptied; that step updates the timer state
// and loads the result beat into the result register, which drives o_res.valid.
// Throughput: one tick per clock unless the receiver stalls; the state update
// is a single saturating add, compare and subtract on the 32-bit accumulator.
// Reset (synchronous, active low) clears the timer state and both stage
// valids and loads mode 0, preset 0, base 1000 ms and tick 10 ms.
// When the receiver stalls, the result register holds, the input register
// fills, and i_in.ready drops until the result is taken.
`timescale 1ns / 1ps
module iec_timer_on_off_pulse (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    iectmr_in_if.sink                                 i_in,
    iectmr_out_if.source                              o_res,
    input  logic                                      i_cfg_we,
    input  logic [iectmr_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [iectmr_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    iectmr_pkg::t_cfg       r_cfg;
    logic                   r_in_valid;
    logic                   r_in_run;
    logic                   r_out_valid;
    iectmr_pkg::t_out_beat  r_out_data;
    logic                   step;
    iectmr_pkg::t_tmr_state core_state;
    iectmr_pkg::t_out_beat  core_result;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= iectmr_pkg::MODE_ON_DELAY;
            r_cfg.preset  <= '0;
            r_cfg.base_ms <= iectmr_pkg::BASE_MS_RESET;
            r_cfg.tick_ms <= iectmr_pkg::TICK_MS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                iectmr_pkg::CFG_MODE:    r_cfg.mode    <= i_cfg_data[1:0];
                iectmr_pkg::CFG_PRESET:  r_cfg.preset  <= i_cfg_data;
                iectmr_pkg::CFG_BASE_MS: r_cfg.base_ms <= i_cfg_data;
                iectmr_pkg::CFG_TICK_MS: r_cfg.tick_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A tick moves on when the result register is free or being emptied.
    assign step       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_run <= i_in.data.run_input;
        end
    end

    iectmr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_run    (r_in_run),
        .i_cfg    (r_cfg),
        .o_state  (core_state),
        .o_result (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= core_result;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    // A processed tick always leaves a result beat behind.
    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed tick produced no result beat");

    // Timer state changes only when a tick is processed.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(core_state))
        else $error("timer state changed without a tick");

    // An empty input register never refuses a beat.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input refused while input register empty");

    // Reset empties the input and result registers.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("stage valid survived reset");

endmodule

// ===== test/tmr_result_checker.sv =====
// Result checker for the PLC timer: predicts each scan result and compares it.
`timescale 1ns / 1ps
module tmr_result_checker
    import iectmr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    iectmr_in_if                     scan_mon,
    iectmr_out_if                    res_mon,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_outstanding
);

    // Register copy, updated from the write port.
    logic [1:0]  cfg_mode;
    logic [15:0] cfg_preset;
    logic [15:0] cfg_base;
    logic [15:0] cfg_tick;

    // Timer state copy.
    logic [COUNT_BITS-1:0] tm_count;
    logic                  tm_done;
    logic                  tm_started;
    logic                  tm_prev;
    logic [ACC_BITS-1:0]   tm_acc;

    // Results predicted for accepted scans, oldest first.
    t_out_beat expected_results[$];

    // Advances the timer by one scan tick and returns the result it reports.
    function automatic t_out_beat next_timer_result(input logic run_in);
        logic                counting;
        logic [ACC_BITS:0]   acc_sum;
        t_out_beat           res;
        counting = 1'b0;

        // Per-mode reaction to the input level and its edges.
        case (cfg_mode)
            MODE_ON_DELAY: begin
                if (!run_in) begin
                    tm_done  = 1'b0;
                    tm_count = '0;
                end else if (tm_count < cfg_preset) begin
                    counting = 1'b1;
                end else begin
                    tm_done = 1'b1;
                end
            end
            MODE_OFF_DELAY: begin
                if (run_in) begin
                    tm_done    = 1'b1;
                    tm_count   = '0;
                    tm_started = 1'b0;
                end else if (tm_prev) begin
                    tm_started = 1'b1;
                end
            end
            MODE_PULSE: begin
                if (run_in && !tm_prev && !tm_started) begin
                    tm_done    = 1'b1;
                    tm_count   = '0;
                    tm_started = 1'b1;
                end
            end
            // The unused mode code freezes the timer.
            default: ;
        endcase

        // A started off-delay or pulse timer runs until it reaches the preset.
        if ((cfg_mode == MODE_OFF_DELAY || cfg_mode == MODE_PULSE) && tm_started) begin
            if (tm_count < cfg_preset) begin
                counting = 1'b1;
            end else begin
                tm_done    = 1'b0;
                tm_count   = '0;
                tm_started = 1'b0;
            end
        end

        // Saturating millisecond accumulation; one base unit per count step.
        if (counting) begin
            acc_sum = {1'b0, tm_acc} + (ACC_BITS + 1)'(cfg_tick);
            if (acc_sum[ACC_BITS]) begin
                tm_acc = '1;
            end else begin
                tm_acc = acc_sum[ACC_BITS-1:0];
            end
            if (tm_acc >= ACC_BITS'(cfg_base)) begin
                if (tm_count != '1) begin
                    tm_count = tm_count + 1'b1;
                end
                tm_acc = tm_acc - ACC_BITS'(cfg_base);
            end
        end

        tm_prev = run_in;
        res.done_res = tm_done;
        res.elapsed  = tm_count[15:0];
        return res;
    endfunction

    // Watch the write port and both channels at every rising edge.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            cfg_mode      = MODE_ON_DELAY;
            cfg_preset    = '0;
            cfg_base      = BASE_MS_RESET;
            cfg_tick      = TICK_MS_RESET;
            tm_count      = '0;
            tm_done       = 1'b0;
            tm_started    = 1'b0;
            tm_prev       = 1'b0;
            tm_acc        = '0;
            expected_results.delete();
            o_fail_count  = 0;
            o_outstanding = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:    cfg_mode   = i_cfg_data[1:0];
                    CFG_PRESET:  cfg_preset = i_cfg_data;
                    CFG_BASE_MS: cfg_base   = i_cfg_data;
                    CFG_TICK_MS: cfg_tick   = i_cfg_data;
                    default: ;
                endcase
            end

            // Results are checked before this edge's scan is predicted, since a
            // scan never produces its result in the cycle it is accepted.
            if (res_mon.valid && res_mon.ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result beat: expected none, %s%0b elapsed=%0d",
                             $time, "got done=", res_mon.data.done_res,
                             res_mon.data.elapsed);
                end else begin
                    want = expected_results.pop_front();
                    if (want.done_res !== res_mon.data.done_res ||
                        want.elapsed !== res_mon.data.elapsed) begin
                        o_fail_count++;
                        $display("%0t: result mismatch: expected done=%0b elapsed=%0d, %s",
                                 $time, want.done_res, want.elapsed, "got");
                        $display("%0t:     actual done=%0b elapsed=%0d",
                                 $time, res_mon.data.done_res, res_mon.data.elapsed);
                    end
                end
            end

            if (scan_mon.valid && scan_mon.ready) begin
                expected_results.push_back(next_timer_result(scan_mon.data.run_input));
            end
            o_outstanding = expected_results.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the PLC timer: clock, reset, scan stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
    import iectmr_pkg::*;

    // The fourth mode code has no enum member; it freezes the timer.
    localparam logic [1:0] MODE_FROZEN = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       fail_total;
    int                       results_due;

    // Idling percentages per phase and the long receiver hold-off.
    int send_idle_pct;
    int stall_pct;
    int hold_request;
    int hold_left;
    int idle_by_phase[4]  = '{0, 51, 0, 18};
    int stall_by_phase[4] = '{0, 0, 51, 18};

    iectmr_in_if  scan_ch ();
    iectmr_out_if res_ch ();

    iec_timer_on_off_pulse uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (scan_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tmr_result_checker scan_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .scan_mon      (scan_ch),
        .res_mon       (res_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_total),
        .o_outstanding (results_due)
    );

    // 100 MHz clock.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request > 0) begin
            res_ch.ready <= 1'b0;
            hold_left = hold_request - 1;
            hold_request = 0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one scan beat after a random idle gap and waits until it is taken.
    task automatic send_scan(input logic run_bit);
        while ($urandom_range(99) < send_idle_pct) begin
            scan_ch.valid <= 1'b0;
            @(posedge clk);
        end
        scan_ch.valid <= 1'b1;
        scan_ch.data.run_input <= run_bit;
        @(posedge clk);
        while (!scan_ch.ready) @(posedge clk);
    endtask

    // Sends the low n bits of a pattern, most significant first.
    task automatic send_bits(input logic [15:0] pattern, input int n);
        int k;
        for (k = n - 1; k >= 0; k--) begin
            send_scan(pattern[k]);
        end
    endtask

    // Stops offering scans until every predicted result has been taken.
    task automatic wait_results_drained;
        scan_ch.valid <= 1'b0;
        do @(negedge clk); while (results_due != 0);
        @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges; the block must be idle.
    task automatic load_timer(input logic [15:0] mode_w, input logic [15:0] preset_w,
                              input logic [15:0] base_w, input logic [15:0] tick_w);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MODE;
        cfg_data <= mode_w;
        @(posedge clk);
        cfg_idx  <= CFG_PRESET;
        cfg_data <= preset_w;
        @(posedge clk);
        cfg_idx  <= CFG_BASE_MS;
        cfg_data <= base_w;
        @(posedge clk);
        cfg_idx  <= CFG_TICK_MS;
        cfg_data <= tick_w;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One random setting followed by input runs long enough to time out, or noise.
    task automatic run_random_segment(input int n_scans);
        int          sel;
        int          ratio;
        int          tick_i;
        int          need;
        int          run_len;
        int          sent;
        int          k;
        bit          noisy;
        logic        level;
        logic [15:0] mode_w;
        logic [15:0] preset_w;
        logic [15:0] base_w;
        logic [15:0] tick_w;

        // Mode code in the low bits, random junk above them.
        mode_w = 16'($urandom_range(0, 65535));
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            mode_w[1:0] = MODE_ON_DELAY;
        end else if (sel < 6) begin
            mode_w[1:0] = MODE_OFF_DELAY;
        end else if (sel < 9) begin
            mode_w[1:0] = MODE_PULSE;
        end else begin
            mode_w[1:0] = MODE_FROZEN;
        end

        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            preset_w = 16'd0;
        end else if (sel == 1) begin
            preset_w = 16'hFFFF;
        end else begin
            preset_w = 16'($urandom_range(1, 6));
        end

        // Keep base within a few ticks so a run reaches the preset quickly.
        sel = $urandom_range(0, 7);
        ratio = $urandom_range(1, 4);
        if (sel == 0) begin
            tick_i = 65535;
            ratio  = 1;
            base_w = 16'hFFFF;
        end else begin
            tick_i = (sel == 1) ? 1 : $urandom_range(2, 100);
            base_w = 16'(tick_i * ratio - $urandom_range(0, tick_i - 1));
        end
        tick_w = 16'(tick_i);

        need = (preset_w > 16'd6) ? 40 : preset_w * ratio + 2;

        wait_results_drained();
        load_timer(mode_w, preset_w, base_w, tick_w);

        noisy = ($urandom_range(0, 4) == 0);
        level = 1'($urandom_range(0, 1));
        sent  = 0;
        while (sent < n_scans) begin
            if (noisy) begin
                send_scan(1'($urandom_range(0, 1)));
                sent++;
            end else begin
                if ($urandom_range(0, 9) < 7) begin
                    run_len = need + $urandom_range(0, 4);
                end else begin
                    run_len = $urandom_range(1, 3);
                end
                for (k = 0; k < run_len && sent < n_scans; k++) begin
                    send_scan(level);
                    sent++;
                end
                level = !level;
            end
        end
    endtask

    // Run time limit.
    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int phase;
        int k;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_MODE;
        cfg_data      = '0;
        scan_ch.valid = 1'b0;
        scan_ch.data  = '0;
        res_ch.ready  = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 0;
        hold_left     = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: on-delay with a zero preset is done at once.
        send_bits(16'b10, 2);

        // On-delay counting with a remainder left in the accumulator.
        wait_results_drained();
        load_timer(16'(MODE_ON_DELAY), 16'd2, 16'd15, 16'd10);
        send_bits(16'b111110, 6);

        // Off-delay with a zero base, mode written with extra high bits.
        wait_results_drained();
        load_timer({14'h3FFF, MODE_OFF_DELAY}, 16'd2, 16'd0, 16'd7);
        send_bits(16'b10001, 5);

        // Pulse with a zero preset times out in the same tick.
        wait_results_drained();
        load_timer(16'(MODE_PULSE), 16'd0, 16'd10, 16'd10);
        send_bits(16'b010, 3);

        // Pulse ignores a rising edge while it is running.
        wait_results_drained();
        load_timer(16'(MODE_PULSE), 16'd4, 16'd10, 16'd10);
        send_bits(16'b01011, 5);

        // Mode change in the middle of a pulse keeps the state.
        wait_results_drained();
        load_timer(16'(MODE_OFF_DELAY), 16'd4, 16'd10, 16'd10);
        send_bits(16'b00, 2);

        // The unused mode code freezes everything but the previous input.
        wait_results_drained();
        load_timer({14'h3FFF, MODE_FROZEN}, 16'd4, 16'd10, 16'd10);
        send_bits(16'b101, 3);

        // All-ones registers.
        wait_results_drained();
        load_timer(16'(MODE_ON_DELAY), 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_bits(16'b10, 2);

        // Random part, one idling style per phase.
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_by_phase[phase];
            stall_pct     = stall_by_phase[phase];
            if (phase == 0) begin
                // Long receiver hold-off while scans keep coming: the block fills.
                wait_results_drained();
                load_timer(16'(MODE_ON_DELAY), 16'd3, 16'd20, 16'd10);
                hold_request = 80;
                for (k = 0; k < 30; k++) begin
                    send_scan(k % 10 != 9);
                end
            end
            repeat (3) run_random_segment(50);
        end

        // A large base with a unit tick: time piles up while the count stays put.
        send_idle_pct = 0;
        stall_pct     = 0;
        wait_results_drained();
        load_timer(16'(MODE_ON_DELAY), 16'd10, 16'hFFFF, 16'd1);
        send_bits(16'b0111111, 7);

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (fail_total == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/iectmr_pkg.sv
sv/iectmr_if.sv
sv/iectmr_core.sv
sv/iec_timer_on_off_pulse.sv
test/tmr_result_checker.sv
test/tb_top.sv
